>>> sv/wre_pkg.sv
// Shared types, widths and constants of the windowed rate and remaining-time estimator.
// No dependencies; every other file imports this package.
`default_nettype none
package wre_pkg;

  localparam int SAMPLE_DEPTH_DEF = 64;

  localparam int TIME_W  = 48;
  localparam int ITEMS_W = 31;
  localparam int BYTES_W = 48;
  localparam int LEFT_W  = 48;
  localparam int MS_W    = 32;
  localparam int WIN_W   = 52;   // window in ns: 32-bit ms times 10^6
  localparam int CIDX_W  = 8;

  localparam int OPA_W  = 48;    // multiplier operands
  localparam int PROD_W = 96;
  localparam int DEN_W  = 68;    // divisor before doubling
  localparam int NUM_W  = PROD_W + 2;
  localparam int RES_W  = 49;
  localparam int ETA_W  = 48;

  localparam logic [CIDX_W-1:0] CFG_ETA_WIN   = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_SPEED_WIN = 8'd1;

  localparam logic [19:0]      NS_PER_MS      = 20'd1000000;
  localparam logic [OPA_W-1:0] K_NS_PER_MS    = 48'd1000000;
  localparam logic [OPA_W-1:0] K_NS_PER_S     = 48'd1000000000;
  localparam logic [OPA_W-1:0] K_NS_PER_S_X100 = 48'd100000000000;

  localparam logic [WIN_W-1:0] ETA_WIN_NS_RST   = 52'd60000000000;
  localparam logic [WIN_W-1:0] SPEED_WIN_NS_RST = 52'd5000000000;

  typedef struct packed {
    logic [TIME_W-1:0]  time_ns;
    logic [ITEMS_W-1:0] items;
    logic [BYTES_W-1:0] bytes;
  } sample_t;

  typedef struct packed {
    logic             go;
    logic [OPA_W-1:0] a;
    logic [OPA_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] n;
    logic [DEN_W-1:0]  d;
    logic              neg;
    logic              eta;   // eta limits instead of rate limits
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] res;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> sv/wre_ifs.sv
// Handshake interfaces for the sample input, result output and configuration write channels.
// Depends on wre_pkg.
`default_nettype none
interface wre_in_if import wre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  sample_time_ns;
  logic [ITEMS_W-1:0] items_done;
  logic [BYTES_W-1:0] bytes_done;
  logic signed [LEFT_W-1:0] bytes_left;
  modport source(output valid, sample_time_ns, items_done, bytes_done, bytes_left,
                 input ready);
  modport sink(input valid, sample_time_ns, items_done, bytes_done, bytes_left,
               output ready);
endinterface

interface wre_out_if import wre_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ETA_W-1:0] eta_ms;
  logic                    eta_valid;
  logic signed [RES_W-1:0] byte_rate;
  logic signed [RES_W-1:0] item_rate_x100;
  logic                    rate_valid;
  modport source(output valid, eta_ms, eta_valid, byte_rate, item_rate_x100, rate_valid,
                 input ready);
  modport sink(input valid, eta_ms, eta_valid, byte_rate, item_rate_x100, rate_valid,
               output ready);
endinterface

interface wre_cfg_if import wre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [MS_W-1:0]   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/wre_ring.sv
// Sample ring storage: one write port, one read port with registered read data.
// Depends on wre_pkg.
`default_nettype none
module wre_ring import wre_pkg::*; #(
  parameter int DEPTH = SAMPLE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire sample_t                  wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output sample_t                       rd_data
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> sv/wre_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, stops when the bits run out.
// Depends on wre_pkg.
`default_nettype none
module wre_mul import wre_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] ash_r, ash_nxt;
  logic [OPA_W-1:0]  bsh_r, bsh_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    ash_nxt  = ash_r;
    bsh_nxt  = bsh_r;
    if (req.go) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      ash_nxt  = PROD_W'(req.a);
      bsh_nxt  = req.b;
    end else if (busy_r) begin
      if (bsh_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (bsh_r[0]) begin
          acc_nxt = acc_r + ash_r;
        end
        ash_nxt = {ash_r[PROD_W-2:0], 1'b0};
        bsh_nxt = {1'b0, bsh_r[OPA_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    ash_r <= ash_nxt;
    bsh_r <= bsh_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule
`default_nettype wire

>>> sv/wre_div.sv
// Restoring divider computing round(n/d) half away from zero, then sign and saturation.
// Depends on wre_pkg.
`default_nettype none
module wre_div import wre_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DD_W  = DEN_W + 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [DD_W-1:0]  den_r, den_nxt;
  logic [DD_W-1:0]  rem_r, rem_nxt;
  logic             neg_r, neg_nxt;
  logic             eta_r, eta_nxt;
  logic [RES_W-1:0] res_r, res_nxt;

  logic [DD_W:0]    rem_sh;
  logic [RES_W-1:0] lim;
  logic [RES_W-1:0] mag;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    eta_nxt  = eta_r;
    res_nxt  = res_r;
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    if (neg_r) begin
      lim = eta_r ? RES_W'(49'h0800000000000) : RES_W'(49'h0FFFFFFFFFFFF);
    end else begin
      lim = eta_r ? RES_W'(49'h07FFFFFFFFFFF) : RES_W'(49'h0FFFFFFFFFFFF);
    end
    if ((q_r[NUM_W-1:RES_W] != '0) || (q_r[RES_W-1:0] > lim)) begin
      mag = lim;
    end else begin
      mag = q_r[RES_W-1:0];
    end
    if (req.go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      num_nxt  = {1'b0, req.n, 1'b0} + NUM_W'(req.d);
      den_nxt  = {req.d, 1'b0};
      rem_nxt  = '0;
      q_nxt    = '0;
      neg_nxt  = req.neg;
      eta_nxt  = req.eta;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? (RES_W'(0) - mag) : mag;
      end else begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = DD_W'(rem_sh - {1'b0, den_r});
          q_nxt   = {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DD_W-1:0];
          q_nxt   = {q_r[NUM_W-2:0], 1'b0};
        end
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    eta_r <= eta_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
`default_nettype wire

>>> sv/windowed_rate_and_eta_estimator.sv
// Top level of the windowed rate and remaining-time estimator: sequencer, window registers.
// Depends on wre_pkg, wre_ifs, wre_ring, wre_mul and wre_div.
//
//   Channel   Dir  Handshake        Word
//   in_ch     in   valid / ready    sample time, items done, bytes done, bytes left
//   out_ch    out  valid / ready    eta_ms, eta_valid, byte_rate, item_rate_x100, rate_valid
//   cfg_ch    in   valid / ready    register index, 32-bit window in ms
//
// One word is worked on at a time. A word takes a ring walk over the stored samples after the
// append (at most DEPTH), two front reads, up to four multiplies (one bit per cycle) and up to
// three divisions (one quotient bit per cycle).
// Reset (synchronous, rst_n low) empties the ring and restores 60000 ms and 5000 ms windows;
// no clearing pass is needed because only entries inside the fill count are ever read.
// A finished result sits in the output register while the next word is accepted; the block
// only stalls at the end of a word if the previous result has still not been taken.
`default_nettype none
module windowed_rate_and_eta_estimator import wre_pkg::*; #(
  parameter int DEPTH = SAMPLE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wre_in_if.sink    in_ch,
  wre_out_if.source out_ch,
  wre_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  // Sequencer states.
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SCAN    = 5'd1;
  localparam logic [4:0] S_DRAIN   = 5'd2;
  localparam logic [4:0] S_PRUNE   = 5'd3;
  localparam logic [4:0] S_RDE     = 5'd4;
  localparam logic [4:0] S_RDS     = 5'd5;
  localparam logic [4:0] S_CAPS    = 5'd6;
  localparam logic [4:0] S_CALC    = 5'd7;
  localparam logic [4:0] S_ETA_M1  = 5'd8;
  localparam logic [4:0] S_ETA_M2  = 5'd9;
  localparam logic [4:0] S_ETA_DIV = 5'd10;
  localparam logic [4:0] S_RATE    = 5'd11;
  localparam logic [4:0] S_BR_M    = 5'd12;
  localparam logic [4:0] S_BR_DIV  = 5'd13;
  localparam logic [4:0] S_IR_M    = 5'd14;
  localparam logic [4:0] S_IR_DIV  = 5'd15;
  localparam logic [4:0] S_OUT     = 5'd16;

  // Ring position of the k-th oldest sample.
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base, logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  logic [4:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] kd_r, kd_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cut_r, cut_nxt;
  logic [CNT_W-1:0] fe_r, fe_nxt;
  logic [CNT_W-1:0] fs_r, fs_nxt;
  logic             app_r, app_nxt;
  logic [WIN_W-1:0] eta_ns_r, eta_ns_nxt;
  logic [WIN_W-1:0] spd_ns_r, spd_ns_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload registers.
  sample_t          newest_r, newest_nxt;
  sample_t          fe_smp_r, fe_smp_nxt;
  sample_t          fs_smp_r, fs_smp_nxt;
  logic [IDX_W-1:0] fe_slot_r, fe_slot_nxt;
  logic [IDX_W-1:0] fs_slot_r, fs_slot_nxt;
  logic [LEFT_W-1:0] left_mag_r, left_mag_nxt;
  logic             left_neg_r, left_neg_nxt;
  logic [PROD_W-1:0] n_r, n_nxt;
  logic [ETA_W-1:0] eta_res_r, eta_res_nxt;
  logic [RES_W-1:0] br_res_r, br_res_nxt;
  logic [RES_W-1:0] ir_res_r, ir_res_nxt;
  logic             eta_ok_r, eta_ok_nxt;
  logic             rate_ok_r, rate_ok_nxt;
  logic [ETA_W-1:0] o_eta_r, o_eta_nxt;
  logic             o_eta_ok_r, o_eta_ok_nxt;
  logic [RES_W-1:0] o_br_r, o_br_nxt;
  logic [RES_W-1:0] o_ir_r, o_ir_nxt;
  logic             o_rate_ok_r, o_rate_ok_nxt;

  logic             in_acc;
  logic             stale;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  sample_t          in_smp;
  sample_t          rd_data;
  logic [WIN_W-1:0] wmax_ns;
  logic [WIN_W:0]   t_cut, t_eta, t_spd;
  logic [CNT_W-1:0] fe_abs, fs_abs;

  // Deltas between the newest sample and the two front samples.
  logic [TIME_W-1:0]  dt_e, dt_s;
  logic               dbe_neg, dbs_neg, di_neg;
  logic [BYTES_W-1:0] dbe_mag, dbs_mag;
  logic [ITEMS_W-1:0] di_mag;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  wre_ring #(.DEPTH(DEPTH)) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_smp),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  wre_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  wre_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && (state_r == S_IDLE);

  assign in_smp.time_ns = in_ch.sample_time_ns;
  assign in_smp.items   = in_ch.items_done;
  assign in_smp.bytes   = in_ch.bytes_done;

  // A sample that does not advance time leaves the ring alone.
  assign stale = (count_r != '0) && (in_ch.sample_time_ns <= newest_r.time_ns);

  assign wmax_ns = (eta_ns_r > spd_ns_r) ? eta_ns_r : spd_ns_r;
  assign t_cut   = (WIN_W + 1)'(rd_data.time_ns) + (WIN_W + 1)'(wmax_ns);
  assign t_eta   = (WIN_W + 1)'(rd_data.time_ns) + (WIN_W + 1)'(eta_ns_r);
  assign t_spd   = (WIN_W + 1)'(rd_data.time_ns) + (WIN_W + 1)'(spd_ns_r);

  // A window front never lies before the prune point.
  assign fe_abs = (fe_r > cut_r) ? fe_r : cut_r;
  assign fs_abs = (fs_r > cut_r) ? fs_r : cut_r;

  assign dt_e    = newest_r.time_ns - fe_smp_r.time_ns;
  assign dt_s    = newest_r.time_ns - fs_smp_r.time_ns;
  assign dbe_neg = newest_r.bytes < fe_smp_r.bytes;
  assign dbe_mag = dbe_neg ? (fe_smp_r.bytes - newest_r.bytes)
                           : (newest_r.bytes - fe_smp_r.bytes);
  assign dbs_neg = newest_r.bytes < fs_smp_r.bytes;
  assign dbs_mag = dbs_neg ? (fs_smp_r.bytes - newest_r.bytes)
                           : (newest_r.bytes - fs_smp_r.bytes);
  assign di_neg  = newest_r.items < fs_smp_r.items;
  assign di_mag  = di_neg ? (fs_smp_r.items - newest_r.items)
                          : (newest_r.items - fs_smp_r.items);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    k_nxt         = k_r;
    kd_nxt        = k_r;
    pend_nxt      = 1'b0;
    cut_nxt       = cut_r;
    fe_nxt        = fe_r;
    fs_nxt        = fs_r;
    app_nxt       = app_r;
    eta_ns_nxt    = eta_ns_r;
    spd_ns_nxt    = spd_ns_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    newest_nxt    = newest_r;
    fe_smp_nxt    = fe_smp_r;
    fs_smp_nxt    = fs_smp_r;
    fe_slot_nxt   = fe_slot_r;
    fs_slot_nxt   = fs_slot_r;
    left_mag_nxt  = left_mag_r;
    left_neg_nxt  = left_neg_r;
    n_nxt         = n_r;
    eta_res_nxt   = eta_res_r;
    br_res_nxt    = br_res_r;
    ir_res_nxt    = ir_res_r;
    eta_ok_nxt    = eta_ok_r;
    rate_ok_nxt   = rate_ok_r;
    o_eta_nxt     = o_eta_r;
    o_eta_ok_nxt  = o_eta_ok_r;
    o_br_nxt      = o_br_r;
    o_ir_nxt      = o_ir_r;
    o_rate_ok_nxt = o_rate_ok_r;
    wr_en         = 1'b0;
    wr_addr       = oldest_r;
    rd_addr       = oldest_r;
    mul_req       = '0;
    div_req       = '0;

    if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_ETA_WIN) begin
        eta_ns_nxt = WIN_W'(cfg_ch.data) * WIN_W'(NS_PER_MS);
      end else if (cfg_ch.index == CFG_SPEED_WIN) begin
        spd_ns_nxt = WIN_W'(cfg_ch.data) * WIN_W'(NS_PER_MS);
      end
    end

    // Ring walk: read data of step k arrives in the cycle after its address.
    if (pend_r) begin
      if (app_r && (t_cut <= (WIN_W + 1)'(newest_r.time_ns))) begin
        cut_nxt = kd_r;
      end
      if (t_eta <= (WIN_W + 1)'(newest_r.time_ns)) begin
        fe_nxt = kd_r;
      end
      if (t_spd <= (WIN_W + 1)'(newest_r.time_ns)) begin
        fs_nxt = kd_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          app_nxt      = !stale;
          k_nxt        = '0;
          cut_nxt      = '0;
          fe_nxt       = '0;
          fs_nxt       = '0;
          eta_ok_nxt   = 1'b0;
          rate_ok_nxt  = 1'b0;
          eta_res_nxt  = '0;
          br_res_nxt   = '0;
          ir_res_nxt   = '0;
          left_neg_nxt = in_ch.bytes_left[LEFT_W-1];
          left_mag_nxt = in_ch.bytes_left[LEFT_W-1] ? (LEFT_W'(0) - in_ch.bytes_left)
                                                    : in_ch.bytes_left;
          if (!stale) begin
            wr_en      = 1'b1;
            newest_nxt = in_smp;
            if (count_r < CNT_W'(DEPTH)) begin
              wr_addr   = wrap_add(oldest_r, count_r);
              count_nxt = count_r + CNT_W'(1);
            end else begin
              wr_addr    = oldest_r;
              oldest_nxt = wrap_add(oldest_r, CNT_W'(1));
            end
          end
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr  = wrap_add(oldest_r, k_r);
        pend_nxt = 1'b1;
        k_nxt    = k_r + CNT_W'(1);
        if (k_r == count_r - CNT_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PRUNE;
      end
      S_PRUNE: begin
        fe_slot_nxt = wrap_add(oldest_r, fe_abs);
        fs_slot_nxt = wrap_add(oldest_r, fs_abs);
        oldest_nxt  = wrap_add(oldest_r, cut_r);
        count_nxt   = count_r - cut_r;
        state_nxt   = S_RDE;
      end
      S_RDE: begin
        rd_addr   = fe_slot_r;
        state_nxt = S_RDS;
      end
      S_RDS: begin
        rd_addr    = fs_slot_r;
        fe_smp_nxt = rd_data;
        state_nxt  = S_CAPS;
      end
      S_CAPS: begin
        fs_smp_nxt = rd_data;
        state_nxt  = S_CALC;
      end
      S_CALC: begin
        if (dbe_mag != '0) begin
          eta_ok_nxt = 1'b1;
          mul_req.go = 1'b1;
          mul_req.a  = left_mag_r;
          mul_req.b  = dt_e;
          state_nxt  = S_ETA_M1;
        end else begin
          state_nxt = S_RATE;
        end
      end
      S_ETA_M1: begin
        if (mul_rsp.done) begin
          n_nxt      = mul_rsp.prod;
          mul_req.go = 1'b1;
          mul_req.a  = dbe_mag;
          mul_req.b  = K_NS_PER_MS;
          state_nxt  = S_ETA_M2;
        end
      end
      S_ETA_M2: begin
        if (mul_rsp.done) begin
          div_req.go  = 1'b1;
          div_req.n   = n_r;
          div_req.d   = mul_rsp.prod[DEN_W-1:0];
          div_req.neg = left_neg_r ^ dbe_neg;
          div_req.eta = 1'b1;
          state_nxt   = S_ETA_DIV;
        end
      end
      S_ETA_DIV: begin
        if (div_rsp.done) begin
          eta_res_nxt = div_rsp.res[ETA_W-1:0];
          state_nxt   = S_RATE;
        end
      end
      S_RATE: begin
        if (dt_s != '0) begin
          rate_ok_nxt = 1'b1;
          mul_req.go  = 1'b1;
          mul_req.a   = dbs_mag;
          mul_req.b   = K_NS_PER_S;
          state_nxt   = S_BR_M;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_BR_M: begin
        if (mul_rsp.done) begin
          div_req.go  = 1'b1;
          div_req.n   = mul_rsp.prod;
          div_req.d   = DEN_W'(dt_s);
          div_req.neg = dbs_neg;
          state_nxt   = S_BR_DIV;
        end
      end
      S_BR_DIV: begin
        if (div_rsp.done) begin
          br_res_nxt = div_rsp.res;
          mul_req.go = 1'b1;
          mul_req.a  = OPA_W'(di_mag);
          mul_req.b  = K_NS_PER_S_X100;
          state_nxt  = S_IR_M;
        end
      end
      S_IR_M: begin
        if (mul_rsp.done) begin
          div_req.go  = 1'b1;
          div_req.n   = mul_rsp.prod;
          div_req.d   = DEN_W'(dt_s);
          div_req.neg = di_neg;
          state_nxt   = S_IR_DIV;
        end
      end
      S_IR_DIV: begin
        if (div_rsp.done) begin
          ir_res_nxt = div_rsp.res;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        // Wait here only while the previous result is still held.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_eta_nxt     = eta_res_r;
          o_eta_ok_nxt  = eta_ok_r;
          o_br_nxt      = br_res_r;
          o_ir_nxt      = ir_res_r;
          o_rate_ok_nxt = rate_ok_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      k_r         <= '0;
      kd_r        <= '0;
      pend_r      <= 1'b0;
      cut_r       <= '0;
      fe_r        <= '0;
      fs_r        <= '0;
      app_r       <= 1'b0;
      eta_ns_r    <= ETA_WIN_NS_RST;
      spd_ns_r    <= SPEED_WIN_NS_RST;
      out_valid_r <= 1'b0;
      eta_ok_r    <= 1'b0;
      rate_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      k_r         <= k_nxt;
      kd_r        <= kd_nxt;
      pend_r      <= pend_nxt;
      cut_r       <= cut_nxt;
      fe_r        <= fe_nxt;
      fs_r        <= fs_nxt;
      app_r       <= app_nxt;
      eta_ns_r    <= eta_ns_nxt;
      spd_ns_r    <= spd_ns_nxt;
      out_valid_r <= out_valid_nxt;
      eta_ok_r    <= eta_ok_nxt;
      rate_ok_r   <= rate_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r    <= newest_nxt;
    fe_smp_r    <= fe_smp_nxt;
    fs_smp_r    <= fs_smp_nxt;
    fe_slot_r   <= fe_slot_nxt;
    fs_slot_r   <= fs_slot_nxt;
    left_mag_r  <= left_mag_nxt;
    left_neg_r  <= left_neg_nxt;
    n_r         <= n_nxt;
    eta_res_r   <= eta_res_nxt;
    br_res_r    <= br_res_nxt;
    ir_res_r    <= ir_res_nxt;
    o_eta_r     <= o_eta_nxt;
    o_eta_ok_r  <= o_eta_ok_nxt;
    o_br_r      <= o_br_nxt;
    o_ir_r      <= o_ir_nxt;
    o_rate_ok_r <= o_rate_ok_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.eta_ms         = o_eta_r;
  assign out_ch.eta_valid      = o_eta_ok_r;
  assign out_ch.byte_rate      = o_br_r;
  assign out_ch.item_rate_x100 = o_ir_r;
  assign out_ch.rate_valid     = o_rate_ok_r;

endmodule
`default_nettype wire

>>> sv/wre_check.sv
// Port-level checker for the estimator, bound to the top level.
// Depends on wre_pkg and on the top level's interface ports.
`default_nettype none
module wre_check import wre_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [ETA_W-1:0] eta_ms,
  input wire logic                    eta_valid,
  input wire logic signed [RES_W-1:0] byte_rate,
  input wire logic signed [RES_W-1:0] item_rate_x100,
  input wire logic                    rate_valid
);

  // A result word waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // Words are worked on one at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an accept");

  a_eta_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !eta_valid |-> eta_ms == '0)
    else $error("remaining time nonzero without valid flag");

  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !rate_valid |-> byte_rate == '0 && item_rate_x100 == '0)
    else $error("rates nonzero without valid flag");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

endmodule

bind windowed_rate_and_eta_estimator wre_check u_wre_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .eta_ms        (out_ch.eta_ms),
  .eta_valid     (out_ch.eta_valid),
  .byte_rate     (out_ch.byte_rate),
  .item_rate_x100(out_ch.item_rate_x100),
  .rate_valid    (out_ch.rate_valid)
);
`default_nettype wire
